// ===== sv/rtbc_pkg.sv =====
`timescale 1ns / 1ps

package rtbc_pkg;

  localparam int unsigned EN_W     = 8;
  localparam int unsigned PCODE_W  = 7;
  localparam int unsigned MCODE_W  = 8;
  localparam int unsigned TWORD_W  = 16;
  localparam int unsigned US_W     = 32;
  localparam int unsigned FCODE_W  = 13;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned MACRO_W  = 20;
  localparam int unsigned PART_W   = 22;

  typedef logic [STAT_W-1:0]  stat_t;
  typedef logic [TWORD_W-1:0] mclk_t;

  localparam stat_t STAT_OK        = 2'd0;
  localparam stat_t STAT_NO_FINAL  = 2'd1;
  localparam stat_t STAT_TOO_SMALL = 2'd2;

  localparam logic [31:0] OVH_START = 32'd1910;
  localparam logic [31:0] OVH_END   = 32'd960;
  localparam logic [31:0] OVH_MSRC  = 32'd660;
  localparam logic [31:0] OVH_TCC   = 32'd590;
  localparam logic [31:0] OVH_DSS2  = 32'd1380;
  localparam logic [31:0] OVH_PRE   = 32'd660;
  localparam logic [31:0] OVH_FINAL = 32'd550;

  localparam logic [PART_W-1:0] MACRO_SCALE = 22'd3813120;
  localparam logic [31:0]       ROUND_HALF  = 32'd500;
  localparam logic [31:0]       NS_PER_US   = 32'd1000;

  localparam int unsigned BIT_FINAL = 7;
  localparam int unsigned BIT_PRE   = 6;
  localparam int unsigned BIT_TCC   = 4;
  localparam int unsigned BIT_DSS   = 3;
  localparam int unsigned BIT_MSRC  = 2;

  function automatic logic [7:0] period_pclks(input logic [PCODE_W-1:0] code);
    logic [7:0] t;
    t = {1'b0, code} + 8'd1;
    return {t[6:0], 1'b0};
  endfunction

  function automatic mclk_t decode_word(input logic [TWORD_W-1:0] word);
    logic [15:0] v;
    v = 16'd0;
    if (word[15:12] == 4'd0) begin
      v = {8'd0, word[7:0]} << word[11:8];
    end
    return v + 16'd1;
  endfunction

endpackage

// ===== sv/rtbc_in_if.sv =====
`timescale 1ns / 1ps

interface rtbc_in_if;
  logic                                valid;
  logic                                ready;
  logic [rtbc_pkg::EN_W-1:0]           step_enables;
  logic [rtbc_pkg::PCODE_W-1:0]        pre_period_code;
  logic [rtbc_pkg::PCODE_W-1:0]        final_period_code;
  logic [rtbc_pkg::MCODE_W-1:0]        msrc_timeout_code;
  logic [rtbc_pkg::TWORD_W-1:0]        pre_timeout_word;
  logic [rtbc_pkg::TWORD_W-1:0]        final_timeout_word;
  logic [rtbc_pkg::US_W-1:0]           requested_budget_us;

  modport source (
    output valid, step_enables, pre_period_code, final_period_code,
           msrc_timeout_code, pre_timeout_word, final_timeout_word, requested_budget_us,
    input  ready
  );

  modport sink (
    input  valid, step_enables, pre_period_code, final_period_code,
           msrc_timeout_code, pre_timeout_word, final_timeout_word, requested_budget_us,
    output ready
  );
endinterface

// ===== sv/rtbc_out_if.sv =====
`timescale 1ns / 1ps

interface rtbc_out_if;
  logic                          valid;
  logic                          ready;
  logic [rtbc_pkg::US_W-1:0]     current_budget_us;
  logic [rtbc_pkg::FCODE_W-1:0]  new_final_code;
  logic [rtbc_pkg::STAT_W-1:0]   set_status;

  modport source (
    output valid, current_budget_us, new_final_code, set_status,
    input  ready
  );

  modport sink (
    input  valid, current_budget_us, new_final_code, set_status,
    output ready
  );
endinterface

// ===== sv/ranging_timing_budget_calc_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Transfer when        Payload
// in_bus    sink       valid && ready       step enables, period codes, timeouts, request
// out_bus   source     valid && ready       current budget, final code, status
//
// One item at a time: a new input is taken only once the last one has left the sequencer.
// Five or six divisions run one after another on one radix-2 divider; the
// final-code normalize shifts the mantissa right until it fits in eight bits.
// in_bus.ready is high only while idle; a result waits in the output register
// and does not block the next input transfer, but the sequencer holds in its
// last step while that register is still full.
// Reset (rst_n low, synchronous) returns to idle with no result pending.

module ranging_timing_budget_calc_unit (
  input  logic         clk,
  input  logic         rst_n,
  rtbc_in_if.sink      in_bus,
  rtbc_out_if.source   out_bus
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_ENC  = 3'd5;
  localparam logic [2:0] ST_NORM = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  localparam logic [2:0] OP_PREMAC = 3'd0;
  localparam logic [2:0] OP_FINMAC = 3'd1;
  localparam logic [2:0] OP_MSRC   = 3'd2;
  localparam logic [2:0] OP_PRE    = 3'd3;
  localparam logic [2:0] OP_FIN    = 3'd4;
  localparam logic [2:0] OP_REQ    = 3'd5;

  localparam logic [1:0] SUM_TCC = 2'd0;
  localparam logic [1:0] SUM_DSS = 2'd1;
  localparam logic [1:0] SUM_PRE = 2'd2;

  logic [2:0]                           state_r, state_nxt;
  logic [2:0]                           op_r, op_nxt;
  logic [1:0]                           sum_k_r, sum_k_nxt;
  logic [rtbc_pkg::EN_W-1:0]            en_r, en_nxt;
  logic [rtbc_pkg::PCODE_W-1:0]         pre_code_r, pre_code_nxt;
  logic [rtbc_pkg::PCODE_W-1:0]         fin_code_r, fin_code_nxt;
  logic [rtbc_pkg::MCODE_W-1:0]         msrc_code_r, msrc_code_nxt;
  rtbc_pkg::mclk_t                      pre_mclks_r, pre_mclks_nxt;
  rtbc_pkg::mclk_t                      fin_mclks_r, fin_mclks_nxt;
  logic [31:0]                          req_r, req_nxt;
  logic [rtbc_pkg::MACRO_W-1:0]         pre_macro_r, pre_macro_nxt;
  logic [rtbc_pkg::MACRO_W-1:0]         fin_macro_r, fin_macro_nxt;
  logic [rtbc_pkg::PART_W-1:0]          msrc_us_r, msrc_us_nxt;
  logic [31:0]                          pre_us_r, pre_us_nxt;
  logic [31:0]                          used_r, used_nxt;
  logic [31:0]                          cur_r, cur_nxt;
  logic [31:0]                          m_r, m_nxt;
  logic [4:0]                           ms_r, ms_nxt;
  logic [rtbc_pkg::FCODE_W-1:0]         code_r, code_nxt;
  rtbc_pkg::stat_t                      status_r, status_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [31:0]                          out_cur_r, out_cur_nxt;
  logic [rtbc_pkg::FCODE_W-1:0]         out_code_r, out_code_nxt;
  rtbc_pkg::stat_t                      out_status_r, out_status_nxt;

  logic [31:0]                          mul_a;
  logic [rtbc_pkg::PART_W-1:0]          mul_b;
  logic [31:0]                          mul_c;
  logic [53:0]                          prod_full;
  logic [31:0]                          div_num;
  logic [31:0]                          div_den;
  logic                                 div_start;
  logic                                 div_done;
  logic [31:0]                          div_quot;

  logic en_final, en_pre, en_tcc, en_dss, en_msrc;

  assign en_final = en_r[rtbc_pkg::BIT_FINAL];
  assign en_pre   = en_r[rtbc_pkg::BIT_PRE];
  assign en_tcc   = en_r[rtbc_pkg::BIT_TCC];
  assign en_dss   = en_r[rtbc_pkg::BIT_DSS];
  assign en_msrc  = en_r[rtbc_pkg::BIT_MSRC];

  always_comb begin
    mul_a   = 32'd0;
    mul_b   = rtbc_pkg::MACRO_SCALE;
    mul_c   = rtbc_pkg::ROUND_HALF;
    div_den = rtbc_pkg::NS_PER_US;
    case (op_r)
      OP_PREMAC: mul_a = {24'd0, rtbc_pkg::period_pclks(pre_code_r)};
      OP_FINMAC: mul_a = {24'd0, rtbc_pkg::period_pclks(fin_code_r)};
      OP_MSRC: begin
        mul_a = {23'd0, {1'b0, msrc_code_r} + 9'd1};
        mul_b = {2'd0, pre_macro_r};
      end
      OP_PRE: begin
        mul_a = {16'd0, pre_mclks_r};
        mul_b = {2'd0, pre_macro_r};
      end
      OP_FIN: begin
        mul_a = {16'd0, fin_mclks_r};
        mul_b = {2'd0, fin_macro_r};
      end
      OP_REQ: begin
        mul_a   = req_r;
        mul_b   = rtbc_pkg::NS_PER_US[rtbc_pkg::PART_W-1:0];
        mul_c   = {13'd0, fin_macro_r[rtbc_pkg::MACRO_W-1:1]};
        div_den = {12'd0, fin_macro_r};
      end
      default: mul_a = 32'd0;
    endcase
  end

  assign prod_full = mul_a * mul_b;
  assign div_num   = prod_full[31:0] + mul_c;

  rtbc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    sum_k_nxt      = sum_k_r;
    en_nxt         = en_r;
    pre_code_nxt   = pre_code_r;
    fin_code_nxt   = fin_code_r;
    msrc_code_nxt  = msrc_code_r;
    pre_mclks_nxt  = pre_mclks_r;
    fin_mclks_nxt  = fin_mclks_r;
    req_nxt        = req_r;
    pre_macro_nxt  = pre_macro_r;
    fin_macro_nxt  = fin_macro_r;
    msrc_us_nxt    = msrc_us_r;
    pre_us_nxt     = pre_us_r;
    used_nxt       = used_r;
    cur_nxt        = cur_r;
    m_nxt          = m_r;
    ms_nxt         = ms_r;
    code_nxt       = code_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_cur_nxt    = out_cur_r;
    out_code_nxt   = out_code_r;
    out_status_nxt = out_status_r;
    div_start      = 1'b0;

    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_bus.valid) begin
          en_nxt        = in_bus.step_enables;
          pre_code_nxt  = in_bus.pre_period_code;
          fin_code_nxt  = in_bus.final_period_code;
          msrc_code_nxt = in_bus.msrc_timeout_code;
          pre_mclks_nxt = rtbc_pkg::decode_word(in_bus.pre_timeout_word);
          fin_mclks_nxt = rtbc_pkg::decode_word(in_bus.final_timeout_word);
          req_nxt       = in_bus.requested_budget_us;
          used_nxt      = rtbc_pkg::OVH_START + rtbc_pkg::OVH_END;
          op_nxt        = OP_PREMAC;
          state_nxt     = ST_MUL;
        end
      end
      ST_MUL: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          case (op_r)
            OP_PREMAC: begin
              pre_macro_nxt = div_quot[rtbc_pkg::MACRO_W-1:0];
              op_nxt        = OP_FINMAC;
              state_nxt     = ST_MUL;
            end
            OP_FINMAC: begin
              fin_macro_nxt = div_quot[rtbc_pkg::MACRO_W-1:0];
              op_nxt        = OP_MSRC;
              state_nxt     = ST_MUL;
            end
            OP_MSRC: begin
              msrc_us_nxt = div_quot[rtbc_pkg::PART_W-1:0];
              op_nxt      = OP_PRE;
              state_nxt   = ST_MUL;
            end
            OP_PRE: begin
              pre_us_nxt = div_quot;
              sum_k_nxt  = SUM_TCC;
              state_nxt  = ST_SUM;
            end
            OP_FIN: begin
              cur_nxt   = en_final
                        ? used_r + div_quot + rtbc_pkg::OVH_FINAL
                        : used_r;
              used_nxt  = used_r + rtbc_pkg::OVH_FINAL;
              state_nxt = ST_CHK;
            end
            OP_REQ: begin
              m_nxt     = div_quot + (en_pre ? {16'd0, pre_mclks_r} : 32'd0);
              state_nxt = ST_ENC;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SUM: begin
        priority case (sum_k_r)
          SUM_TCC: begin
            if (en_tcc) begin
              used_nxt = used_r + {10'd0, msrc_us_r} + rtbc_pkg::OVH_TCC;
            end
            sum_k_nxt = SUM_DSS;
          end
          SUM_DSS: begin
            priority if (en_dss) begin
              used_nxt = used_r + {9'd0, msrc_us_r, 1'b0} + rtbc_pkg::OVH_DSS2;
            end else if (en_msrc) begin
              used_nxt = used_r + {10'd0, msrc_us_r} + rtbc_pkg::OVH_MSRC;
            end
            sum_k_nxt = SUM_PRE;
          end
          default: begin
            if (en_pre) begin
              used_nxt      = used_r + pre_us_r + rtbc_pkg::OVH_PRE;
              fin_mclks_nxt = fin_mclks_r - pre_mclks_r;
            end
            op_nxt    = OP_FIN;
            state_nxt = ST_MUL;
          end
        endcase
      end
      ST_CHK: begin
        priority if (!en_final) begin
          status_nxt = rtbc_pkg::STAT_NO_FINAL;
          code_nxt   = '0;
          state_nxt  = ST_OUT;
        end else if (used_r > req_r) begin
          status_nxt = rtbc_pkg::STAT_TOO_SMALL;
          code_nxt   = '0;
          state_nxt  = ST_OUT;
        end else begin
          req_nxt   = req_r - used_r;
          op_nxt    = OP_REQ;
          state_nxt = ST_MUL;
        end
      end
      ST_ENC: begin
        status_nxt = rtbc_pkg::STAT_OK;
        if (m_r == 32'd0) begin
          code_nxt  = '0;
          state_nxt = ST_OUT;
        end else begin
          m_nxt     = m_r - 32'd1;
          ms_nxt    = 5'd0;
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (m_r[31:8] != 24'd0) begin
          m_nxt  = {1'b0, m_r[31:1]};
          ms_nxt = ms_r + 5'd1;
        end else begin
          code_nxt  = {ms_r, m_r[7:0]};
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_bus.ready) begin
          out_cur_nxt    = cur_r;
          out_code_nxt   = code_r;
          out_status_nxt = status_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_PREMAC;
      sum_k_r     <= SUM_TCC;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      sum_k_r     <= sum_k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    en_r         <= en_nxt;
    pre_code_r   <= pre_code_nxt;
    fin_code_r   <= fin_code_nxt;
    msrc_code_r  <= msrc_code_nxt;
    pre_mclks_r  <= pre_mclks_nxt;
    fin_mclks_r  <= fin_mclks_nxt;
    req_r        <= req_nxt;
    pre_macro_r  <= pre_macro_nxt;
    fin_macro_r  <= fin_macro_nxt;
    msrc_us_r    <= msrc_us_nxt;
    pre_us_r     <= pre_us_nxt;
    used_r       <= used_nxt;
    cur_r        <= cur_nxt;
    m_r          <= m_nxt;
    ms_r         <= ms_nxt;
    code_r       <= code_nxt;
    status_r     <= status_nxt;
    out_cur_r    <= out_cur_nxt;
    out_code_r   <= out_code_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_bus.ready              = (state_r == ST_IDLE);
  assign out_bus.valid             = out_valid_r;
  assign out_bus.current_budget_us = out_cur_r;
  assign out_bus.new_final_code    = out_code_r;
  assign out_bus.set_status        = out_status_r;

`ifndef SYNTHESIS
  a_code_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != rtbc_pkg::STAT_OK) |-> out_code_r == '0)
    else $error("final code not zero on error status");

  a_accept_starts_seq: assert property (@(posedge clk) disable iff (!rst_n)
    in_bus.valid && in_bus.ready |=> state_r == ST_MUL && op_r == OP_PREMAC)
    else $error("sequencer did not start after input transfer");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the wait state");

  a_norm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NORM |-> ms_r <= 5'd24)
    else $error("exponent overran during normalize");

  a_out_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT && out_valid_r && !out_bus.ready |=> state_r == ST_OUT)
    else $error("pending result overwritten");
`endif

endmodule

// ===== sv/rtbc_div.sv =====
`timescale 1ns / 1ps

module rtbc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quot
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial = {rem_r, quo_r[31]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = 32'd0;
      quo_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[31:0] : trial[31:0];
      quo_nxt = {quo_r[30:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule

// ===== tb/ranging_timing_budget_calc_unit_tb.sv =====
`timescale 1ns / 1ps

module ranging_timing_budget_calc_unit_tb;

  localparam int unsigned RANDOM_REQUESTS = 1700;
  localparam int unsigned DRAIN_CYCLES    = 300;
  localparam int unsigned CYCLE_LIMIT     = 3000000;

  typedef struct packed {
    logic [rtbc_pkg::EN_W-1:0]    step_enables;
    logic [rtbc_pkg::PCODE_W-1:0] pre_period_code;
    logic [rtbc_pkg::PCODE_W-1:0] final_period_code;
    logic [rtbc_pkg::MCODE_W-1:0] msrc_timeout_code;
    logic [rtbc_pkg::TWORD_W-1:0] pre_timeout_word;
    logic [rtbc_pkg::TWORD_W-1:0] final_timeout_word;
    logic [rtbc_pkg::US_W-1:0]    requested_budget_us;
  } budget_request_t;

  typedef struct packed {
    logic [rtbc_pkg::US_W-1:0]    current_budget_us;
    logic [rtbc_pkg::FCODE_W-1:0] new_final_code;
    rtbc_pkg::stat_t              set_status;
  } budget_result_t;

  logic clk;
  logic rst_n;

  rtbc_in_if  in_bus ();
  rtbc_out_if out_bus ();

  ranging_timing_budget_calc_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  budget_request_t budget_request_q[$];
  budget_result_t  budget_result_q[$];
  budget_request_t request_on_bus;
  budget_result_t  result_due;
  int unsigned     transfers_in;
  int unsigned     idle_phase;
  int unsigned     mismatch_count;
  int unsigned     cycle_count;

  function automatic logic [31:0] pulse_period_ns(
    input logic [rtbc_pkg::PCODE_W-1:0] code);
    logic [7:0] pclks;
    pclks = ({1'b0, code} + 8'd1) << 1;
    return (32'd2304 * {24'd0, pclks} * 32'd1655 + 32'd500) / 32'd1000;
  endfunction

  function automatic logic [31:0] mclks_to_us(input logic [31:0] mclks,
                                              input logic [31:0] macro_ns);
    return (mclks * macro_ns + 32'd500) / 32'd1000;
  endfunction

  function automatic logic [15:0] decode_timeout(
    input logic [rtbc_pkg::TWORD_W-1:0] word);
    logic [15:0] v;
    v = (word[15:8] < 8'd16) ? ({8'd0, word[7:0]} << word[11:8]) : 16'd0;
    return v + 16'd1;
  endfunction

  // budget of all enabled steps other than final range (MSRC only without DSS), fixed overheads included
  function automatic logic [31:0] step_overhead_us(input budget_request_t r);
    logic [31:0] pre_macro;
    logic [31:0] msrc_us;
    logic [31:0] pre_us;
    logic [31:0] used;
    pre_macro = pulse_period_ns(r.pre_period_code);
    msrc_us   = mclks_to_us({24'd0, r.msrc_timeout_code} + 32'd1, pre_macro);
    pre_us    = mclks_to_us({16'd0, decode_timeout(r.pre_timeout_word)}, pre_macro);
    used      = rtbc_pkg::OVH_START + rtbc_pkg::OVH_END;
    if (r.step_enables[rtbc_pkg::BIT_TCC]) used += msrc_us + rtbc_pkg::OVH_TCC;
    if (r.step_enables[rtbc_pkg::BIT_DSS]) used += 2 * msrc_us + rtbc_pkg::OVH_DSS2;
    else if (r.step_enables[rtbc_pkg::BIT_MSRC]) used += msrc_us + rtbc_pkg::OVH_MSRC;
    if (r.step_enables[rtbc_pkg::BIT_PRE]) used += pre_us + rtbc_pkg::OVH_PRE;
    return used;
  endfunction

  function automatic budget_result_t predict_budget(input budget_request_t r);
    budget_result_t res;
    logic [31:0]    fin_macro;
    logic [31:0]    used;
    logic [31:0]    m;
    logic [31:0]    ls;
    logic [31:0]    ms;
    logic [15:0]    pre_mclks;
    logic [15:0]    fin_mclks;
    fin_macro = pulse_period_ns(r.final_period_code);
    pre_mclks = decode_timeout(r.pre_timeout_word);
    fin_mclks = decode_timeout(r.final_timeout_word);
    if (r.step_enables[rtbc_pkg::BIT_PRE]) fin_mclks = fin_mclks - pre_mclks;
    used = step_overhead_us(r);
    res.current_budget_us = used;
    res.new_final_code    = '0;
    if (r.step_enables[rtbc_pkg::BIT_FINAL]) begin
      res.current_budget_us += mclks_to_us({16'd0, fin_mclks}, fin_macro)
                             + rtbc_pkg::OVH_FINAL;
    end
    if (!r.step_enables[rtbc_pkg::BIT_FINAL]) begin
      res.set_status = rtbc_pkg::STAT_NO_FINAL;
    end else begin
      used += rtbc_pkg::OVH_FINAL;
      if (used > r.requested_budget_us) begin
        res.set_status = rtbc_pkg::STAT_TOO_SMALL;
      end else begin
        if (fin_macro == 32'd0) m = '1;
        else m = ((r.requested_budget_us - used) * rtbc_pkg::NS_PER_US + fin_macro / 2)
                 / fin_macro;
        if (r.step_enables[rtbc_pkg::BIT_PRE]) m += {16'd0, pre_mclks};
        if (m != 32'd0) begin
          ls = m - 32'd1;
          ms = 32'd0;
          while (ls[31:8] != 24'd0) begin
            ls = ls >> 1;
            ms++;
          end
          res.new_final_code = {ms[4:0], ls[7:0]};
        end
        res.set_status = rtbc_pkg::STAT_OK;
      end
    end
    return res;
  endfunction

  // with budget_rel set, the request is an offset from the smallest budget that fits
  task automatic queue_request(input logic [7:0] en, input logic [6:0] pre_pc,
                               input logic [6:0] fin_pc, input logic [7:0] msrc,
                               input logic [15:0] pre_w, input logic [15:0] fin_w,
                               input logic [31:0] budget, input bit budget_rel);
    budget_request_t r;
    r.step_enables        = en;
    r.pre_period_code     = pre_pc;
    r.final_period_code   = fin_pc;
    r.msrc_timeout_code   = msrc;
    r.pre_timeout_word    = pre_w;
    r.final_timeout_word  = fin_w;
    r.requested_budget_us = budget;
    if (budget_rel) begin
      r.requested_budget_us = step_overhead_us(r) + rtbc_pkg::OVH_FINAL + budget;
    end
    budget_request_q.push_back(r);
  endtask

  function automatic logic [15:0] random_timeout_word();
    logic [7:0] ex;
    ex = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 15))
                                       : 8'($urandom_range(16, 255));
    return {ex, 8'($urandom_range(0, 255))};
  endfunction

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always_comb idle_phase = (transfers_in / 100) % 4;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        budget_result_q.push_back(predict_budget(request_on_bus));
        transfers_in++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (budget_request_q.size() != 0 &&
            $urandom_range(0, 99) >= (idle_phase == 1 ? 45 : idle_phase == 3 ? 9 : 0)) begin
          request_on_bus = budget_request_q.pop_front();
          in_bus.step_enables        <= request_on_bus.step_enables;
          in_bus.pre_period_code     <= request_on_bus.pre_period_code;
          in_bus.final_period_code   <= request_on_bus.final_period_code;
          in_bus.msrc_timeout_code   <= request_on_bus.msrc_timeout_code;
          in_bus.pre_timeout_word    <= request_on_bus.pre_timeout_word;
          in_bus.final_timeout_word  <= request_on_bus.final_timeout_word;
          in_bus.requested_budget_us <= request_on_bus.requested_budget_us;
          in_bus.valid               <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (budget_result_q.size() == 0) begin
          $display("%0t: result transfer with none due: budget %0d code %0d status %0d",
                   $time, out_bus.current_budget_us, out_bus.new_final_code,
                   out_bus.set_status);
          mismatch_count++;
        end else begin
          result_due = budget_result_q.pop_front();
          if (out_bus.current_budget_us !== result_due.current_budget_us) begin
            $display("%0t: current_budget_us expected %0d actual %0d", $time,
                     result_due.current_budget_us, out_bus.current_budget_us);
            mismatch_count++;
          end
          if (out_bus.new_final_code !== result_due.new_final_code) begin
            $display("%0t: new_final_code expected 0x%0h actual 0x%0h", $time,
                     result_due.new_final_code, out_bus.new_final_code);
            mismatch_count++;
          end
          if (out_bus.set_status !== result_due.set_status) begin
            $display("%0t: set_status expected %0d actual %0d", $time,
                     result_due.set_status, out_bus.set_status);
            mismatch_count++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(0, 99) >= (idle_phase == 2 ? 45 :
                                                  idle_phase == 3 ? 9 : 0));
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, budget_result_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] offset;
    int unsigned pick;
    clk                        = 1'b0;
    rst_n                      = 1'b0;
    transfers_in               = 0;
    mismatch_count             = 0;
    cycle_count                = 0;
    in_bus.valid               = 1'b0;
    in_bus.step_enables        = '0;
    in_bus.pre_period_code     = '0;
    in_bus.final_period_code   = '0;
    in_bus.msrc_timeout_code   = '0;
    in_bus.pre_timeout_word    = '0;
    in_bus.final_timeout_word  = '0;
    in_bus.requested_budget_us = '0;
    out_bus.ready              = 1'b0;

    queue_request(8'h00, 7'd0, 7'd0, 8'd0, 16'h0000, 16'h0000, 32'd0, 1'b0);
    queue_request(8'hFF, 7'd127, 7'd127, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b0);
    queue_request(8'h80, 7'd7, 7'd5, 8'd20, 16'h0010, 16'h0150, 32'd100000, 1'b0);
    queue_request(8'h80, 7'd7, 7'd5, 8'd20, 16'h0010, 16'h0150, 32'd0, 1'b0);
    queue_request(8'h80, 7'd7, 7'd5, 8'd20, 16'h0010, 16'h0000, 32'd0, 1'b1);
    queue_request(8'h80, 7'd7, 7'd5, 8'd20, 16'h0010, 16'h0000, 32'hFFFF_FFFF, 1'b1);
    queue_request(8'hDC, 7'd7, 7'd5, 8'd20, 16'h0010, 16'h0150, 32'd0, 1'b1);
    queue_request(8'hC0, 7'd9, 7'd127, 8'd0, 16'h0020, 16'h0330, 32'd50000, 1'b0);
    queue_request(8'hC0, 7'd9, 7'd127, 8'd0, 16'h0320, 16'h0330, 32'd50000, 1'b0);
    queue_request(8'hDC, 7'd127, 7'd3, 8'd200, 16'h0AFF, 16'h0400, 32'd30000000, 1'b0);
    queue_request(8'h80, 7'd5, 7'd5, 8'd0, 16'h10FF, 16'h2080, 32'd90000, 1'b0);
    queue_request(8'hC0, 7'd5, 7'd5, 8'd0, 16'h0FFF, 16'h0FFF, 32'd4000000, 1'b0);
    queue_request(8'hC0, 7'd5, 7'd5, 8'd0, 16'h0F01, 16'hFF01, 32'd4000000, 1'b0);
    queue_request(8'h8C, 7'd11, 7'd9, 8'd60, 16'h0000, 16'h0280, 32'd200000, 1'b0);
    queue_request(8'h84, 7'd11, 7'd9, 8'd60, 16'h0000, 16'h0280, 32'd200000, 1'b0);
    queue_request(8'h90, 7'd11, 7'd9, 8'd60, 16'h0000, 16'h0280, 32'd200000, 1'b0);
    queue_request(8'hC8, 7'd13, 7'd9, 8'd60, 16'h0390, 16'h0120, 32'd800000, 1'b0);
    queue_request(8'hDC, 7'd13, 7'd9, 8'd60, 16'h0390, 16'h0120, 32'hFFFF_FFFF, 1'b1);
    queue_request(8'hDC, 7'd13, 7'd9, 8'd60, 16'h0390, 16'h0120, 32'd1, 1'b1);
    queue_request(8'hA3, 7'd0, 7'd0, 8'd255, 16'h00FF, 16'h00FF, 32'hFFFF_FFFF, 1'b0);
    queue_request(8'h5C, 7'd126, 7'd126, 8'd128, 16'h8000, 16'h0001, 32'h8000_0000, 1'b0);

    repeat (RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2: offset = $urandom();
        3, 4, 5: offset = $urandom_range(0, 200000);
        6:       offset = -$urandom_range(1, 50);
        7:       offset = $urandom_range(0, 3);
        default: offset = $urandom_range(0, 100000);
      endcase
      queue_request((($urandom_range(0, 99) < 80) ? 8'h80 : 8'h00) | 8'($urandom_range(0, 255)),
                    7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                    8'($urandom_range(0, 255)), random_timeout_word(),
                    random_timeout_word(), offset, pick inside {[3:7]});
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (budget_request_q.size() != 0 || in_bus.valid || budget_result_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && budget_result_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0t: %0d mismatches, %0d results outstanding", $time, mismatch_count,
               budget_result_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
